// File: design/tds_pkg.sv
`default_nettype none
package tds_pkg;

  localparam int ID_W    = 10;
  localparam int OPEN_W  = 11;
  localparam int CNT_W   = 5;
  localparam int LIMIT_W = 11;

  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_ADD_DEP = 3'd1;
  localparam logic [2:0] KIND_LAUNCH  = 3'd2;
  localparam logic [2:0] KIND_RESOLVE = 3'd3;
  localparam logic [2:0] KIND_DELETE  = 3'd4;
  localparam logic [2:0] KIND_QUERY   = 3'd5;

  localparam logic [1:0] ST_UNSCHED  = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_LAUNCHED = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_DEPS_FULL = 2'd2;
  localparam logic [1:0] ERR_INVALID   = 2'd3;

  localparam logic [OPEN_W-1:0] OPEN_MAX = '1;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] task_id;
    logic [ID_W-1:0] dep_id;
  } req_t;

  // packed MSB first: result_id ends up in the low bits
  typedef struct packed {
    logic [1:0]        error;
    logic [CNT_W-1:0]  dep_count;
    logic [OPEN_W-1:0] open_deps;
    logic [1:0]        status;
    logic              launch;
    logic [ID_W-1:0]   result_id;
  } res_t;

endpackage
`default_nettype wire

// File: design/tds_ram.sv
`default_nettype none
module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/tds_front.sv
`default_nettype none
module tds_front
  import tds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_valid,
  output      logic        s_ready,
  input  wire logic [23:0] s_data,
  input  wire logic [2:0]  s_user,
  output      logic        q_valid,
  input  wire logic        q_ready,
  output      req_t        q_req
);

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;

  // undefined kinds are taken and dropped
  assign keep    = s_user <= KIND_QUERY;
  assign s_ready = count != 2'd2;
  assign push    = s_valid && s_ready && keep;
  assign q_valid = count != 2'd0;
  assign pop     = q_valid && q_ready;
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: s_user, task_id: s_data[9:0], dep_id: s_data[19:10]};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: design/tds_back.sv
`default_nettype none
module tds_back
  import tds_pkg::*;
#(
  parameter int TASKS          = 1024,
  parameter int MAX_DEPENDENTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [LIMIT_W-1:0] table_limit,
  input  wire logic               q_valid,
  output      logic               q_ready,
  input  wire req_t               q_req,
  output      logic               m_valid,
  input  wire logic               m_ready,
  output      res_t               m_res,
  output      logic               m_last
);

  localparam int IW = $clog2(TASKS);
  localparam int UW = $clog2(MAX_DEPENDENTS + 1);
  localparam int LDEPTH = TASKS * MAX_DEPENDENTS;
  localparam int LW = $clog2(LDEPTH);
  localparam int EW = 1 + 2 + OPEN_W + UW;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [OPEN_W-1:0] open;
    logic [UW-1:0]     used;
  } ent_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_TRD  = 11'b00000000010,
    S_DRD  = 11'b00000000100,
    S_EXEC = 11'b00000001000,
    S_ADD2 = 11'b00000010000,
    S_LRD  = 11'b00000100000,
    S_LDEP = 11'b00001000000,
    S_DEPX = 11'b00010000000,
    S_FIN  = 11'b00100000000,
    S_FRD  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state, state_next, ret, ret_next, walk_next;
  req_t   req, req_next;
  ent_t   trec, trec_next, drec, drec_next, upd, e_rd;
  logic [LIMIT_W-1:0] cc, cc_next;
  logic [UW-1:0]      idx, idx_next;
  logic [ID_W-1:0]    dcur, dcur_next;
  logic               found, found_next;
  res_t               pend, pend_next, res, res_next, out_res, ores_next;
  logic               res_last, last_next, out_valid, ov_next, out_last, olast_next;

  logic          e_we;
  logic [IW-1:0] e_waddr, e_raddr;
  ent_t          e_wdata;
  logic [EW-1:0] e_rdata;
  logic          l_we;
  logic [LW-1:0] l_waddr, l_raddr;
  logic [ID_W-1:0] l_wdata, l_rdata;

  function automatic logic [IW-1:0] eidx(logic [ID_W-1:0] id);
    return IW'(id);
  endfunction

  function automatic logic [LW-1:0] laddr(logic [ID_W-1:0] owner, logic [UW-1:0] slot);
    return LW'(eidx(owner)) * LW'(MAX_DEPENDENTS) + LW'(slot);
  endfunction

  function automatic logic id_ok(logic [ID_W-1:0] id, logic [LIMIT_W-1:0] cnt, logic v);
    return (32'(id) < TASKS) && ({1'b0, id} < cnt) && v;
  endfunction

  function automatic res_t mk(logic [ID_W-1:0] id, logic l, ent_t e);
    return '{error: ERR_NONE, dep_count: CNT_W'(e.used), open_deps: e.open,
             status: e.status, launch: l, result_id: id};
  endfunction

  function automatic res_t err_res(logic [ID_W-1:0] id, logic [1:0] code);
    return '{error: code, dep_count: '0, open_deps: '0, status: ST_UNSCHED,
             launch: 1'b0, result_id: id};
  endfunction

  tds_ram #(.WIDTH(EW), .DEPTH(TASKS)) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  tds_ram #(.WIDTH(ID_W), .DEPTH(LDEPTH)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  assign e_rd    = e_rdata;
  assign q_ready = state == S_IDLE;
  assign m_valid = out_valid;
  assign m_res   = out_res;
  assign m_last  = out_last;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    req_next   = req;
    trec_next  = trec;
    drec_next  = drec;
    cc_next    = cc;
    idx_next   = idx;
    dcur_next  = dcur;
    found_next = found;
    pend_next  = pend;
    res_next   = res;
    last_next  = res_last;
    ov_next    = out_valid;
    ores_next  = out_res;
    olast_next = out_last;
    upd        = trec;
    walk_next  = (UW'(idx + 1'b1) < trec.used) ? S_LRD : S_FIN;
    e_we    = 1'b0;
    e_waddr = eidx(req.task_id);
    e_wdata = trec;
    e_raddr = eidx(q_req.task_id);
    l_we    = 1'b0;
    l_waddr = laddr(req.dep_id, drec.used);
    l_wdata = req.task_id;
    l_raddr = laddr(req.task_id, idx);
    if (out_valid && m_ready) ov_next = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          req_next   = q_req;
          state_next = (q_req.kind == KIND_CREATE) ? S_EXEC : S_TRD;
        end
      end
      S_TRD: begin
        trec_next = e_rd;
        e_raddr   = eidx(req.dep_id);
        if (!id_ok(req.task_id, cc, e_rd.valid)) begin
          res_next   = err_res(req.task_id, ERR_INVALID);
          last_next  = 1'b1;
          ret_next   = S_IDLE;
          state_next = S_OUT;
        end else if (req.kind == KIND_ADD_DEP) begin
          state_next = S_DRD;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_DRD: begin
        drec_next = e_rd;
        if (!id_ok(req.dep_id, cc, e_rd.valid)) begin
          res_next   = err_res(req.task_id, ERR_INVALID);
          last_next  = 1'b1;
          ret_next   = S_IDLE;
          state_next = S_OUT;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        last_next  = 1'b1;
        ret_next   = S_IDLE;
        state_next = S_OUT;
        case (req.kind)
          KIND_CREATE: begin
            if (32'(cc) >= 32'(table_limit) || 32'(cc) >= TASKS) begin
              res_next = err_res('0, ERR_FULL);
            end else begin
              upd      = '{valid: 1'b1, status: ST_UNSCHED, open: '0, used: '0};
              e_we     = 1'b1;
              e_waddr  = IW'(cc);
              e_wdata  = upd;
              cc_next  = cc + 1'b1;
              res_next = mk(ID_W'(cc), 1'b0, upd);
            end
          end
          KIND_ADD_DEP: begin
            if (32'(drec.used) >= MAX_DEPENDENTS) begin
              res_next = err_res(req.task_id, ERR_DEPS_FULL);
            end else begin
              l_we = 1'b1;
              if (trec.open != OPEN_MAX) upd.open = trec.open + 1'b1;
              upd.status = ST_PENDING;
              if (req.task_id == req.dep_id) upd.used = trec.used + 1'b1;
              e_we     = 1'b1;
              e_wdata  = upd;
              res_next = mk(req.task_id, 1'b0, upd);
              if (req.task_id != req.dep_id) state_next = S_ADD2;
            end
          end
          KIND_LAUNCH: begin
            if (trec.open == '0) begin
              upd.status = ST_LAUNCHED;
              e_we       = 1'b1;
              e_wdata    = upd;
            end
            res_next = mk(req.task_id, trec.open == '0, upd);
          end
          KIND_DELETE: begin
            upd.valid = 1'b0;
            e_we      = 1'b1;
            e_wdata   = upd;
            res_next  = mk(req.task_id, 1'b0, trec);
          end
          KIND_RESOLVE: begin
            idx_next   = '0;
            found_next = 1'b0;
            state_next = (trec.used == '0) ? S_FIN : S_LRD;
          end
          default: begin
            res_next = mk(req.task_id, 1'b0, trec);
          end
        endcase
      end
      S_ADD2: begin
        upd        = drec;
        upd.used   = drec.used + 1'b1;
        e_we       = 1'b1;
        e_waddr    = eidx(req.dep_id);
        e_wdata    = upd;
        state_next = S_OUT;
      end
      S_LRD: begin
        state_next = S_LDEP;
      end
      S_LDEP: begin
        dcur_next  = l_rdata;
        e_raddr    = eidx(l_rdata);
        state_next = S_DEPX;
      end
      S_DEPX: begin
        upd        = e_rd;
        idx_next   = idx + 1'b1;
        state_next = walk_next;
        if (id_ok(dcur, cc, e_rd.valid) && e_rd.open != '0) begin
          upd.open = e_rd.open - 1'b1;
          if (upd.open == '0) upd.status = ST_LAUNCHED;
          e_we    = 1'b1;
          e_waddr = eidx(dcur);
          e_wdata = upd;
          if (upd.open == '0) begin
            pend_next  = mk(dcur, 1'b1, upd);
            found_next = 1'b1;
            if (found) begin
              res_next   = pend;
              last_next  = 1'b0;
              ret_next   = walk_next;
              state_next = S_OUT;
            end
          end
        end
      end
      S_FIN: begin
        if (found) begin
          res_next   = pend;
          last_next  = 1'b1;
          ret_next   = S_IDLE;
          state_next = S_OUT;
        end else begin
          e_raddr    = eidx(req.task_id);
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        res_next   = mk(req.task_id, 1'b0, e_rd);
        last_next  = 1'b1;
        ret_next   = S_IDLE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_ready) begin
          ov_next    = 1'b1;
          ores_next  = res;
          olast_next = res_last;
          state_next = ret;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    trec     <= trec_next;
    drec     <= drec_next;
    idx      <= idx_next;
    dcur     <= dcur_next;
    pend     <= pend_next;
    res      <= res_next;
    res_last <= last_next;
    out_res  <= ores_next;
    out_last <= olast_next;
    ret      <= ret_next;
    if (rst) begin
      state     <= S_IDLE;
      cc        <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cc        <= cc_next;
      found     <= found_next;
      out_valid <= ov_next;
    end
  end

endmodule
`default_nettype wire

// File: design/task_dependency_scoreboard.sv
// Task dependency scoreboard.
// Requests enter on s_axis: tuser[2:0] is the kind (create, add dependency,
// launch check, resolve, delete, query), tdata carries task_id and dep_id.
// Results leave on m_axis, tlast marks the final result of a request.
// cfg_* writes table_limit, the number of entries that may be created.
// A two-entry request queue decouples intake from the sequencer, and an
// output register lets the next request start while a result is stalled.
// Requests run one at a time. Resolve visits each stored dependent once:
// it reads the list slot, then the entry through the single read port of
// the entry table, and lowers open_deps where it is nonzero. Each launched
// dependent after the first sends out the one found before it during the
// walk.
// Reset empties the queue, drops any result and sets table_limit to 1024;
// the table needs no clearing pass. A stalled receiver holds the result
// and halts the sequencer once the next result is ready.
`default_nettype none
module task_dependency_scoreboard
  import tds_pkg::*;
#(
  parameter int TASKS          = 1024,
  parameter int MAX_DEPENDENTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,  // task_id, dep_id
  input  wire logic [2:0]         s_axis_tuser,  // kind
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [31:0]        m_axis_tdata,  // result_id, launch, task_status,
                                                 // open_deps, dependent_count, error
  output      logic               m_axis_tlast,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] table_limit;
  logic q_valid, q_ready;
  req_t q_req;
  res_t m_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= LIMIT_W'(1024);
    end else if (cfg_valid) begin
      table_limit <= cfg_data;
    end
  end

  tds_front u_front (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_data(s_axis_tdata), .s_user(s_axis_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  tds_back #(.TASKS(TASKS), .MAX_DEPENDENTS(MAX_DEPENDENTS)) u_back (
    .clk(clk), .rst(rst), .table_limit(table_limit),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_res(m_res), .m_last(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, m_res};

endmodule
`default_nettype wire

// File: design/tds_checker.sv
`default_nettype none
module tds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[30:29] != 2'd0 |-> m_axis_tlast)
    else $error("error result not last");

  a_launch_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[12:11] == 2'd2)
    else $error("launch without launched status");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[30:29] != 2'd0 |->
      m_axis_tdata[28:10] == 19'd0)
    else $error("error result carries entry data");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");

endmodule

bind task_dependency_scoreboard tds_checker u_tds_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
